// ===== rtl/pointer_location_hash_table_core_assert.svh =====
// Assertion macros for the pointer location hash table checker.
// Uses the clk and rst_n names of the module that includes it.
`ifndef POINTER_LOCATION_HASH_TABLE_CORE_ASSERT_SVH
`define POINTER_LOCATION_HASH_TABLE_CORE_ASSERT_SVH
// same-cycle implication
`define PLH_AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plh check failed");
// next-cycle implication
`define PLH_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plh check failed");
`endif

// ===== rtl/plh_pkg.sv =====
// Shared types and constants of the pointer location hash table.
// No dependencies.
package plh_pkg;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 48;
  localparam int DEV_W   = 8;
  localparam int COUNT_W = 32;

  localparam logic [26:0] HASH_MUL = 27'h45d9f3b;

  localparam logic [2:0] OP_REG   = 3'd0;
  localparam logic [2:0] OP_UNREG = 3'd1;
  localparam logic [2:0] OP_QUERY = 3'd2;
  localparam logic [2:0] OP_REC   = 3'd3;
  localparam logic [2:0] OP_PF    = 3'd4;
  localparam logic [2:0] OP_CLR   = 3'd5;

  localparam logic [DEV_W-1:0] DEV_HOST = 8'hFF;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [DEV_W-1:0]   device;
    logic [1:0]         flags;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// ===== rtl/pointer_location_hash_table_core.sv =====
// Top level of the pointer location hash table.
// Depends on plh_pkg, plh_hash and plh_ram.
//
// Usage:
//   Drive in_* and pulse start while busy is low; the item is taken at that
//   edge. Only a query gives a result: out_valid is high for one cycle with
//   out_found, out_location, out_entry_size, out_entry_pinned,
//   out_entry_managed and out_hit_count. The receiver cannot stall.
//   A keyed item goes through hashing (two rounds through one shared
//   multiplier), a bucket row read and a compare and write back; a query
//   result is registered from the compare step, and busy stays high until
//   the write back, so a new item is taken only after the last one is done.
//   A null key (but for clear all) or unknown code leaves busy low, and a
//   null-key query result shows the next cycle.
//   Clear all sweeps the bucket memory one row a cycle with busy high.
//   After reset the same sweep runs.
//   Each memory row holds all ways of one bucket.
module pointer_location_hash_table_core import plh_pkg::*; #(
  parameter int NUM_BUCKETS     = 4096,
  parameter int WAYS_PER_BUCKET = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_operation,
  input  logic [KEY_W-1:0]          in_key,
  input  logic [SIZE_W-1:0]         in_buf_size,
  input  logic signed [DEV_W-1:0]   in_device,
  input  logic                      in_pinned,
  input  logic                      in_managed,
  output logic                      out_valid,
  output logic                      out_found,
  output logic signed [DEV_W-1:0]   out_location,
  output logic [SIZE_W-1:0]         out_entry_size,
  output logic                      out_entry_pinned,
  output logic                      out_entry_managed,
  output logic [COUNT_W-1:0]        out_hit_count
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int WAY_W = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int ROW_W = WAYS_PER_BUCKET * $bits(entry_t);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;

  logic [2:0]         st_r, st_nxt;
  logic [IDX_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [2:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [SIZE_W-1:0]  size_r;
  logic [DEV_W-1:0]   dev_r;
  logic [1:0]         flags_r;
  logic               accept;
  logic               h_go;
  logic               h_done;
  logic [IDX_W-1:0]   h_bucket;
  logic [IDX_W-1:0]   bucket_r;

  entry_t [WAYS_PER_BUCKET-1:0] row;
  entry_t [WAYS_PER_BUCKET-1:0] new_row;
  logic [ROW_W-1:0]   rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ROW_W-1:0]   wr_data;

  logic [WAYS_PER_BUCKET-1:0] hit_vec, free_vec;
  logic [WAY_W-1:0]   hit_idx, free_idx;
  logic               any_hit, any_free;
  entry_t             sel;
  logic [COUNT_W-1:0] cnt_inc;

  logic                ov_r, ov_nxt;
  logic                of_r, of_nxt;
  logic [DEV_W-1:0]    oloc_r, oloc_nxt;
  logic [SIZE_W-1:0]   osize_r, osize_nxt;
  logic [1:0]          oflags_r, oflags_nxt;
  logic [COUNT_W-1:0]  ocnt_r, ocnt_nxt;

  assign busy   = (st_r != S_IDLE);
  assign accept = start && !busy;
  assign h_go   = accept && (in_operation < OP_CLR) && (in_key != '0);

  plh_hash #(.IDX_W(IDX_W)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (h_go),
    .key    (in_key),
    .done   (h_done),
    .bucket (h_bucket)
  );

  plh_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (h_done),
    .rd_addr (h_bucket),
    .rd_data (rd_data)
  );

  assign row = rd_data;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      hit_vec[w]  = row[w].valid && (row[w].key == key_r);
      free_vec[w] = !row[w].valid;
    end
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_idx = WAY_W'(w);
      if (free_vec[w]) free_idx = WAY_W'(w);
    end
  end

  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;
  assign sel      = row[hit_idx];
  assign cnt_inc  = (sel.count == '1) ? sel.count : sel.count + 1'b1;

  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    new_row      = row;
    wr_en        = 1'b0;
    wr_addr      = bucket_r;
    ov_nxt       = 1'b0;
    of_nxt       = 1'b0;
    oloc_nxt     = DEV_HOST;
    osize_nxt    = '0;
    oflags_nxt   = '0;
    ocnt_nxt     = '0;
    case (st_r)
      S_CLR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        new_row      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(NUM_BUCKETS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_CLR) begin
            clr_addr_nxt = '0;
            st_nxt       = S_CLR;
          end else if (h_go) begin
            st_nxt = S_HASH;
          end else if (in_operation == OP_QUERY && in_key == '0) begin
            ov_nxt = 1'b1;
          end
        end
      end
      S_HASH: begin
        if (h_done) st_nxt = S_EVAL;
      end
      S_EVAL: begin
        st_nxt = S_IDLE;
        case (op_r)
          OP_REG: begin
            if (any_hit) begin
              new_row[hit_idx].size   = size_r;
              new_row[hit_idx].device = dev_r;
              new_row[hit_idx].flags  = flags_r;
              wr_en = 1'b1;
            end else if (any_free) begin
              new_row[free_idx] = '{valid: 1'b1, key: key_r, size: size_r,
                                    device: dev_r, flags: flags_r, count: '0};
              wr_en = 1'b1;
            end
          end
          OP_UNREG: begin
            if (any_hit) begin
              new_row[hit_idx].valid = 1'b0;
              wr_en = 1'b1;
            end
          end
          OP_QUERY: begin
            ov_nxt = 1'b1;
            if (any_hit) begin
              new_row[hit_idx].count = cnt_inc;
              wr_en      = 1'b1;
              of_nxt     = 1'b1;
              oloc_nxt   = sel.device;
              osize_nxt  = sel.size;
              oflags_nxt = sel.flags;
              ocnt_nxt   = cnt_inc;
            end
          end
          OP_REC: begin
            if (any_hit) begin
              new_row[hit_idx].count  = cnt_inc;
              new_row[hit_idx].device = dev_r;
              wr_en = 1'b1;
            end
          end
          OP_PF: begin
            if (any_hit) begin
              new_row[hit_idx].count  = cnt_inc;
              new_row[hit_idx].device = dev_r;
              wr_en = 1'b1;
            end else if (any_free) begin
              new_row[free_idx] = '{valid: 1'b1, key: key_r, size: '0,
                                    device: dev_r, flags: 2'b00, count: '0};
              wr_en = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign wr_data = new_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_CLR;
      clr_addr_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clr_addr_r <= clr_addr_nxt;
      ov_r       <= ov_nxt;
    end
    of_r     <= of_nxt;
    oloc_r   <= oloc_nxt;
    osize_r  <= osize_nxt;
    oflags_r <= oflags_nxt;
    ocnt_r   <= ocnt_nxt;
    if (h_done) bucket_r <= h_bucket;
    if (accept) begin
      op_r    <= in_operation;
      key_r   <= in_key;
      size_r  <= in_buf_size;
      dev_r   <= in_device;
      flags_r <= {in_managed, in_pinned};
    end
  end

  assign out_valid         = ov_r;
  assign out_found         = of_r;
  assign out_location      = oloc_r;
  assign out_entry_size    = osize_r;
  assign out_entry_pinned  = oflags_r[0];
  assign out_entry_managed = oflags_r[1];
  assign out_hit_count     = ocnt_r;

endmodule

// ===== rtl/plh_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module plh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/plh_hash.sv =====
// Multi-cycle double xor-shift multiply hash of a 64-bit key to a bucket.
// Depends on plh_pkg; one shared 32x27 multiplier.
module plh_hash import plh_pkg::*; #(
  parameter int IDX_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [IDX_W-1:0] bucket
);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_LO   = 2'd1;
  localparam logic [1:0] H_HI   = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic             round_r, round_nxt;
  logic             done_r, done_nxt;
  logic [KEY_W-1:0] x_r, x_nxt;
  logic [KEY_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] bucket_r, bucket_nxt;
  logic [31:0]      mul_a;
  logic [58:0]      prod;
  logic [KEY_W-1:0] acc;
  logic [KEY_W-1:0] mix;

  assign mul_a = (st_r == H_LO) ? x_r[31:0] : x_r[63:32];
  assign prod  = 59'(mul_a) * 59'(HASH_MUL);
  assign acc   = lo_r + {prod[31:0], 32'd0};
  assign mix   = (acc >> 16) ^ acc;

  always_comb begin
    st_nxt     = st_r;
    round_nxt  = round_r;
    done_nxt   = 1'b0;
    x_nxt      = x_r;
    lo_nxt     = lo_r;
    bucket_nxt = bucket_r;
    case (st_r)
      H_IDLE: begin
        if (go) begin
          x_nxt     = (key >> 16) ^ key;
          round_nxt = 1'b0;
          st_nxt    = H_LO;
        end
      end
      H_LO: begin
        lo_nxt = {5'd0, prod};
        st_nxt = H_HI;
      end
      H_HI: begin
        if (!round_r) begin
          x_nxt     = mix;
          round_nxt = 1'b1;
          st_nxt    = H_LO;
        end else begin
          bucket_nxt = mix[IDX_W-1:0];
          done_nxt   = 1'b1;
          st_nxt     = H_IDLE;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    round_r  <= round_nxt;
    x_r      <= x_nxt;
    lo_r     <= lo_nxt;
    bucket_r <= bucket_nxt;
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule

// ===== rtl/plh_checker.sv =====
// Port-level checker for the pointer location hash table, bound to the top.
// Depends on plh_pkg and pointer_location_hash_table_core_assert.svh.
`include "pointer_location_hash_table_core_assert.svh"

module plh_checker import plh_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [2:0]              in_operation,
  input logic                    out_valid,
  input logic                    out_found,
  input logic signed [DEV_W-1:0] out_location,
  input logic [COUNT_W-1:0]      out_hit_count
);

  `PLH_AST_NOW(a_res_cause, out_valid, $past(busy) || $past(start))
  `PLH_AST_NOW(a_miss_vals, out_valid && !out_found, out_location == DEV_HOST && out_hit_count == '0)
  `PLH_AST_NEXT(a_clr_busy, start && !busy && in_operation == OP_CLR, busy)
  `PLH_AST_NOW(a_rst_sweep, !$past(rst_n), busy)

endmodule

bind pointer_location_hash_table_core plh_checker u_plh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_operation  (in_operation),
  .out_valid     (out_valid),
  .out_found     (out_found),
  .out_location  (out_location),
  .out_hit_count (out_hit_count)
);

// ===== tb/pointer_location_hash_table_core_test.sv =====
// Testbench of pointer_location_hash_table_core: random and directed table requests
// against a behavioral bucket/way predictor, query results checked field by field.
// Depends on plh_pkg and the RTL of the table core.
`timescale 1ns / 100ps

module pointer_location_hash_table_core_test;
  import plh_pkg::*;

  localparam int NB     = 4096;
  localparam int WAYS   = 4;
  localparam int SLOTS  = NB * WAYS;
  localparam int LIMIT  = 400000;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  typedef struct {
    logic [2:0]              op;
    logic [KEY_W-1:0]        key;
    logic [SIZE_W-1:0]       size;
    logic signed [DEV_W-1:0] dev;
    logic                    pin;
    logic                    man;
  } request_t;

  typedef struct {
    logic                    found;
    logic signed [DEV_W-1:0] loc;
    logic [SIZE_W-1:0]       size;
    logic                    pin;
    logic                    man;
    logic [COUNT_W-1:0]      cnt;
  } lookup_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_operation;
  logic [KEY_W-1:0] in_key;
  logic [SIZE_W-1:0] in_buf_size;
  logic signed [DEV_W-1:0] in_device;
  logic in_pinned, in_managed;
  logic out_valid, out_found, out_entry_pinned, out_entry_managed;
  logic signed [DEV_W-1:0] out_location;
  logic [SIZE_W-1:0] out_entry_size;
  logic [COUNT_W-1:0] out_hit_count;

  pointer_location_hash_table_core #(.NUM_BUCKETS(NB), .WAYS_PER_BUCKET(WAYS)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key), .in_buf_size(in_buf_size),
    .in_device(in_device), .in_pinned(in_pinned), .in_managed(in_managed),
    .out_valid(out_valid), .out_found(out_found), .out_location(out_location),
    .out_entry_size(out_entry_size), .out_entry_pinned(out_entry_pinned),
    .out_entry_managed(out_entry_managed), .out_hit_count(out_hit_count)
  );

  bit                 slot_used [SLOTS];
  logic [KEY_W-1:0]   slot_key  [SLOTS];
  logic [SIZE_W-1:0]  slot_size [SLOTS];
  logic [DEV_W-1:0]   slot_dev  [SLOTS];
  logic [1:0]         slot_flag [SLOTS];
  logic [COUNT_W-1:0] slot_cnt  [SLOTS];

  request_t pending_reqs[$];
  lookup_t  pending_lookups[$];
  logic [KEY_W-1:0] key_pool[$];
  request_t cur;
  int errors = 0;
  int cycles = 0;
  int idle_left;
  int burst_left;
  int clears_left = 4;
  bit go;
  int gap;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic int bucket_index(logic [KEY_W-1:0] k);
    logic [63:0] p;
    logic [31:0] h;
    p = k;
    p = ((p >> 16) ^ p) * 64'h45d9f3b;
    p = ((p >> 16) ^ p) * 64'h45d9f3b;
    h = p[31:0] ^ p[47:16];
    return int'(h % NB);
  endfunction

  function automatic logic [KEY_W-1:0] key_in_bucket(int b);
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom} | 64'd1;
    while (bucket_index(k) != b) k++;
    return k;
  endfunction

  function automatic void apply_request(request_t r);
    int base, hit, hole;
    lookup_t res;
    res = '{1'b0, DEV_HOST, '0, 1'b0, 1'b0, '0};
    if (r.op == OP_CLR) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      return;
    end
    if (r.op > OP_CLR) return;
    if (r.key == '0) begin
      if (r.op == OP_QUERY) pending_lookups.push_back(res);
      return;
    end
    base = bucket_index(r.key) * WAYS;
    hit = -1;
    hole = -1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (slot_used[base + w] && slot_key[base + w] == r.key) hit = base + w;
      if (!slot_used[base + w]) hole = base + w;
    end
    case (r.op)
      OP_REG: begin
        if (hit < 0 && hole >= 0) begin
          hit = hole;
          slot_used[hit] = 1'b1;
          slot_key[hit] = r.key;
          slot_cnt[hit] = '0;
        end
        if (hit >= 0) begin
          slot_size[hit] = r.size;
          slot_dev[hit] = r.dev;
          slot_flag[hit] = {r.man, r.pin};
        end
      end
      OP_UNREG: if (hit >= 0) slot_used[hit] = 1'b0;
      OP_QUERY: begin
        if (hit >= 0) begin
          if (slot_cnt[hit] != '1) slot_cnt[hit]++;
          res = '{1'b1, slot_dev[hit], slot_size[hit], slot_flag[hit][0],
                  slot_flag[hit][1], slot_cnt[hit]};
        end
        pending_lookups.push_back(res);
      end
      OP_REC: if (hit >= 0) begin
        if (slot_cnt[hit] != '1) slot_cnt[hit]++;
        slot_dev[hit] = r.dev;
      end
      default: begin
        if (hit >= 0) begin
          if (slot_cnt[hit] != '1) slot_cnt[hit]++;
          slot_dev[hit] = r.dev;
        end else if (hole >= 0) begin
          slot_used[hole] = 1'b1;
          slot_key[hole] = r.key;
          slot_size[hole] = '0;
          slot_dev[hole] = r.dev;
          slot_flag[hole] = '0;
          slot_cnt[hole] = '0;
        end
      end
    endcase
  endfunction

  function automatic void queue_req(logic [2:0] op, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] sz,
                                    logic signed [DEV_W-1:0] d, logic p, logic m);
    request_t r;
    r = '{op, k, sz, d, p, m};
    pending_reqs.push_back(r);
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left <= 0;
      burst_left <= 0;
    end else begin
      go = start;
      gap = idle_left;
      if (start && !busy) begin
        apply_request(cur);
        go = 1'b0;
        if (burst_left > 0) begin
          gap = 0;
          burst_left <= burst_left - 1;
        end else begin
          gap = $urandom_range(0, 16);
          if ($urandom_range(0, 40) == 0) burst_left <= $urandom_range(10, 60);
        end
      end
      if (!go) begin
        if (gap > 0) gap--;
        else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          in_operation <= cur.op;
          in_key <= cur.key;
          in_buf_size <= cur.size;
          in_device <= cur.dev;
          in_pinned <= cur.pin;
          in_managed <= cur.man;
          go = 1'b1;
        end
      end
      start <= go;
      idle_left <= gap;
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t unexpected result: expected none actual found=%0b", $time, out_found);
        errors++;
      end else begin
        e = pending_lookups.pop_front();
        check_field("found", e.found, out_found);
        check_field("location", e.loc, out_location);
        check_field("entry_size", e.size, out_entry_size);
        check_field("entry_pinned", e.pin, out_entry_pinned);
        check_field("entry_managed", e.man, out_entry_managed);
        check_field("hit_count", e.cnt, out_hit_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[pointer_location_hash_table_core] ERROR");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] crowd [6];
    logic [KEY_W-1:0] k;
    int sel;
    logic [2:0] op;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_REG;
    in_key = '0;
    in_buf_size = '0;
    in_device = '0;
    in_pinned = 1'b0;
    in_managed = 1'b0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;

    // crowd one bucket beyond its ways
    sel = $urandom_range(0, NB - 1);
    foreach (crowd[i]) crowd[i] = key_in_bucket(sel);
    queue_req(OP_REG, '1, '1, 8'sd126, 1'b1, 1'b1);
    queue_req(OP_QUERY, '1, '0, '0, 1'b0, 1'b0);
    queue_req(OP_REG, '0, 48'h1234, 8'sd3, 1'b1, 1'b0);
    queue_req(OP_QUERY, '0, '0, '0, 1'b0, 1'b0);
    queue_req(OP_REC, '1, '0, -8'sd1, 1'b0, 1'b0);
    queue_req(OP_PF, '1, '0, 8'sd0, 1'b0, 1'b0);
    queue_req(OP_QUERY, '1, '0, '0, 1'b0, 1'b0);
    queue_req(OP_PF, crowd[0], '1, 8'sd5, 1'b1, 1'b1);
    queue_req(OP_QUERY, crowd[0], '0, '0, 1'b0, 1'b0);
    for (int i = 1; i < 5; i++) queue_req(OP_REG, crowd[i], 48'(i), 8'(i), i[0], i[1]);
    queue_req(OP_QUERY, crowd[4], '0, '0, 1'b0, 1'b0);
    queue_req(OP_PF, crowd[5], '0, 8'sd7, 1'b0, 1'b0);
    queue_req(OP_QUERY, crowd[5], '0, '0, 1'b0, 1'b0);
    queue_req(OP_REG, crowd[2], 48'h0, -8'sd1, 1'b1, 1'b1);
    queue_req(OP_UNREG, crowd[1], '0, '0, 1'b0, 1'b0);
    queue_req(OP_REG, crowd[4], 48'h55, 8'sd9, 1'b0, 1'b1);
    queue_req(OP_QUERY, crowd[2], '0, '0, 1'b0, 1'b0);
    queue_req(OP_QUERY, crowd[4], '0, '0, 1'b0, 1'b0);
    queue_req(OP_BAD6, crowd[2], '1, '1, 1'b1, 1'b1);
    queue_req(OP_BAD7, crowd[2], '1, '1, 1'b1, 1'b1);
    queue_req(OP_CLR, '0, '0, '0, 1'b0, 1'b0);
    queue_req(OP_QUERY, '1, '0, '0, 1'b0, 1'b0);
    queue_req(OP_QUERY, crowd[2], '0, '0, 1'b0, 1'b0);

    foreach (crowd[i]) key_pool.push_back(crowd[i]);
    for (int b = 0; b < 3; b++) begin
      sel = $urandom_range(0, NB - 1);
      for (int i = 0; i < 6; i++) key_pool.push_back(key_in_bucket(sel));
    end
    for (int i = 0; i < 40; i++) key_pool.push_back({$urandom, $urandom});

    for (int n = 0; n < 850; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) op = OP_REG;
      else if (sel < 35) op = OP_UNREG;
      else if (sel < 65) op = OP_QUERY;
      else if (sel < 80) op = OP_REC;
      else if (sel < 97) op = OP_PF;
      else if (sel < 98 && clears_left > 0) begin
        op = OP_CLR;
        clears_left--;
      end else op = 3'($urandom_range(6, 7));
      sel = $urandom_range(0, 99);
      if (sel < 85) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (sel < 95) k = {$urandom, $urandom};
      else k = '0;
      queue_req(op, k, {$urandom, $urandom}, 8'($urandom_range(0, 127) - 1),
                $urandom_range(0, 1), $urandom_range(0, 1));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() > 0 || start) @(posedge clk);
    while (pending_lookups.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[pointer_location_hash_table_core] OK");
    end else begin
      $display("[pointer_location_hash_table_core] ERROR");
    end
    $finish;
  end

endmodule
